// ----- rtl/itoa_pkg.sv -----
`timescale 1ns / 1ps
// itoa_pkg: payload types, controller/datapath link structs and ascii constants
// shared by all modules of integer_to_ascii_formatter_core; no dependencies

package itoa_pkg;

   // input fields fixed by the interface
   localparam int VALUE_BITS = 64;
   localparam int WIDTH_BITS = 6;
   localparam int CHAR_BITS  = 8;

   // decimal digits needed for a 64-bit magnitude, one nibble each
   localparam int NUM_DIGITS  = 20;
   localparam int DIGIT_BITS  = 4 * NUM_DIGITS;
   localparam int COUNT_BITS  = $clog2(NUM_DIGITS + 1);
   localparam int STEP_BITS   = $clog2(VALUE_BITS);

   localparam logic [CHAR_BITS-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [CHAR_BITS-1:0] CHAR_UPPER = 8'h41;
   localparam logic [CHAR_BITS-1:0] CHAR_LOWER = 8'h61;
   localparam logic [CHAR_BITS-1:0] CHAR_MINUS = 8'h2d;
   localparam logic [3:0]           DEC_RADIX  = 4'd10;

   // character source select
   localparam logic [1:0] SEL_SIGN  = 2'd0;
   localparam logic [1:0] SEL_PAD   = 2'd1;
   localparam logic [1:0] SEL_DIGIT = 2'd2;

   typedef struct packed {
      logic [VALUE_BITS-1:0] value;
      logic                  is_signed;
      logic                  hex_base;
      logic                  upper_letters;
      logic [WIDTH_BITS-1:0] min_width;
      logic [CHAR_BITS-1:0]  pad_char;
   } req_payload_type;

   typedef struct packed {
      logic [CHAR_BITS-1:0] out_char;
      logic                 last_char;
   } rsp_payload_type;

   typedef struct packed {
      logic       load;
      logic       conv_step;
      logic       norm_step;
      logic       pad_load;
      logic       pad_dec;
      logic       digit_step;
      logic       emit;
      logic [1:0] sel;
   } dp_cmd_type;

   typedef struct packed {
      logic hex;
      logic neg;
      logic conv_last;
      logic norm_done;
      logic pad_zero;
      logic last_digit;
      logic emit_ok;
   } dp_status_type;

endpackage

// ----- rtl/integer_to_ascii_formatter_core.sv -----
`timescale 1ns / 1ps
// integer_to_ascii_formatter_core: top level joining itoa_ctrl and itoa_dp
// depends on itoa_pkg, itoa_ctrl, itoa_dp
//
// usage
//  - req channel: one beat carries a 64-bit value plus format fields (signed
//    flag, hex base, letter case, minimum width, pad character)
//  - rsp channel: one beat per output character, last_char set on the final
//    character of the run; a run is 1 to max(MAX_WIDTH, 20) characters
//  - one number at a time; req_ready is high only while the sequencer idles,
//    which already includes the cycle the final character sits in the output
//    register, so the next number loads while that character waits
//  - decimal: double-dabble conversion of all 64 bits, one bit per cycle, then
//    up to 19 leading zero digits dropped, one per cycle
//  - hex: no conversion step, then the same leading zero drop
//  - the padding is sized as the zero drop ends and the pad phase is left once
//    its count is zero; then one character per cycle while rsp_ready stays high
//  - a stalled receiver holds the current character in the output register
//    and freezes the sequencer; nothing is dropped
//  - synchronous reset clears the sequencer and the output valid; no
//    character is pending after reset

module integer_to_ascii_formatter_core #(
   parameter int MAX_WIDTH = 40
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  itoa_pkg::req_payload_type req_payload,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output itoa_pkg::rsp_payload_type rsp_payload
);
   import itoa_pkg::*;

   // command and status link between sequencer and datapath
   dp_cmd_type    cmd;
   dp_status_type status;

   itoa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   itoa_dp #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .cmd         (cmd),
      .status      (status),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   // after a number is taken, req_ready is low in the following cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("new beat accepted while previous number still in progress");

   // the load command fires exactly on an accepted beat
   a_load_on_accept: assert property (@(posedge clock) disable iff (reset)
      cmd.load == (req_valid && req_ready))
      else $error("datapath load out of step with input handshake");

endmodule

// ----- rtl/itoa_dp.sv -----
`timescale 1ns / 1ps
// itoa_dp: datapath with double-dabble converter, digit normalizer, pad counter
// and output register; depends on itoa_pkg, driven by itoa_ctrl commands

module itoa_dp #(
   parameter int MAX_WIDTH = 40
) (
   input  logic                      clock,
   input  logic                      reset,
   input  itoa_pkg::req_payload_type req_payload,
   input  itoa_pkg::dp_cmd_type      cmd,
   output itoa_pkg::dp_status_type   status,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output itoa_pkg::rsp_payload_type rsp_payload
);
   import itoa_pkg::*;

   localparam logic [WIDTH_BITS-1:0] MaxW = WIDTH_BITS'(MAX_WIDTH);

   logic [VALUE_BITS-1:0] bin_ff, bin_in;
   logic [DIGIT_BITS-1:0] digits_ff, digits_in;
   logic [STEP_BITS-1:0]  step_ff, step_in;
   logic [COUNT_BITS-1:0] nd_ff, nd_in;
   logic [WIDTH_BITS-1:0] width_ff, width_in;
   logic [WIDTH_BITS-1:0] pad_ff, pad_in;
   logic                  neg_ff, neg_in;
   logic                  hex_ff, hex_in;
   logic                  upper_ff, upper_in;
   logic [CHAR_BITS-1:0]  padc_ff, padc_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_payload_type       rsp_ff, rsp_in;

   logic [VALUE_BITS-1:0] mag;
   logic                  ld_neg;
   logic [WIDTH_BITS-1:0] sat_w;
   logic [DIGIT_BITS-1:0] adj;
   logic [3:0]            top_dig;
   logic [CHAR_BITS-1:0]  dig_char;
   logic [WIDTH_BITS-1:0] nd_w;

   // load-time sign handling and width saturation
   always_comb begin
      ld_neg = req_payload.is_signed & ~req_payload.hex_base
               & req_payload.value[VALUE_BITS-1];
      mag    = ld_neg ? (VALUE_BITS'(0) - req_payload.value) : req_payload.value;
      sat_w  = (req_payload.min_width > MaxW) ? MaxW : req_payload.min_width;
      if (ld_neg && sat_w != '0) begin
         sat_w = sat_w - WIDTH_BITS'(1);
      end
   end

   // add-3 correction on every bcd nibble before the shift
   always_comb begin
      for (int i = 0; i < NUM_DIGITS; i++) begin
         adj[4*i +: 4] = (digits_ff[4*i +: 4] >= 4'd5) ? digits_ff[4*i +: 4] + 4'd3
                                                      : digits_ff[4*i +: 4];
      end
   end

   assign top_dig = digits_ff[DIGIT_BITS-1 -: 4];
   assign nd_w    = WIDTH_BITS'(nd_ff);

   always_comb begin
      if (top_dig < DEC_RADIX) begin
         dig_char = CHAR_ZERO + CHAR_BITS'(top_dig);
      end else begin
         dig_char = (upper_ff ? CHAR_UPPER : CHAR_LOWER) + CHAR_BITS'(top_dig - DEC_RADIX);
      end
   end

   always_comb begin
      bin_in    = bin_ff;
      digits_in = digits_ff;
      step_in   = step_ff;
      nd_in     = nd_ff;
      width_in  = width_ff;
      pad_in    = pad_ff;
      neg_in    = neg_ff;
      hex_in    = hex_ff;
      upper_in  = upper_ff;
      padc_in   = padc_ff;
      if (cmd.load) begin
         neg_in    = ld_neg;
         hex_in    = req_payload.hex_base;
         upper_in  = req_payload.upper_letters;
         padc_in   = req_payload.pad_char;
         width_in  = sat_w;
         step_in   = '0;
         nd_in     = COUNT_BITS'(NUM_DIGITS);
         bin_in    = mag;
         digits_in = req_payload.hex_base ? DIGIT_BITS'(mag) : '0;
      end
      if (cmd.conv_step) begin
         {digits_in, bin_in} = {adj[DIGIT_BITS-2:0], bin_ff, 1'b0};
         step_in = step_ff + STEP_BITS'(1);
      end
      if (cmd.norm_step || cmd.digit_step) begin
         digits_in = {digits_ff[DIGIT_BITS-5:0], 4'h0};
         nd_in     = nd_ff - COUNT_BITS'(1);
      end
      if (cmd.pad_load) begin
         pad_in = (width_ff > nd_w) ? width_ff - nd_w : '0;
      end
      if (cmd.pad_dec) begin
         pad_in = pad_ff - WIDTH_BITS'(1);
      end
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.emit) begin
         rsp_valid_in     = 1'b1;
         rsp_in.last_char = 1'b0;
         case (cmd.sel)
            SEL_SIGN:  rsp_in.out_char = CHAR_MINUS;
            SEL_PAD:   rsp_in.out_char = padc_ff;
            default: begin
               rsp_in.out_char  = dig_char;
               rsp_in.last_char = (nd_ff == COUNT_BITS'(1));
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      bin_ff    <= bin_in;
      digits_ff <= digits_in;
      step_ff   <= step_in;
      nd_ff     <= nd_in;
      width_ff  <= width_in;
      pad_ff    <= pad_in;
      neg_ff    <= neg_in;
      hex_ff    <= hex_in;
      upper_ff  <= upper_in;
      padc_ff   <= padc_in;
      rsp_ff    <= rsp_in;
   end

   always_comb begin
      status.hex        = hex_ff;
      status.neg        = neg_ff;
      status.conv_last  = (step_ff == {STEP_BITS{1'b1}});
      status.norm_done  = (top_dig != 4'h0) || (nd_ff == COUNT_BITS'(1));
      status.pad_zero   = (pad_ff == '0);
      status.last_digit = (nd_ff == COUNT_BITS'(1));
      status.emit_ok    = ~rsp_valid_ff | rsp_ready;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   a_emit_sets_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> rsp_valid_ff)
      else $error("emitted character not held in output register");

   a_dec_digit_range: assert property (@(posedge clock) disable iff (reset)
      (cmd.digit_step && !hex_ff) |-> (top_dig < DEC_RADIX))
      else $error("decimal digit out of range after conversion");

endmodule

// ----- rtl/itoa_ctrl.sv -----
`timescale 1ns / 1ps
// itoa_ctrl: sequencing state machine for conversion, normalization and emission
// depends on itoa_pkg; drives itoa_dp through command and status structs

module itoa_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  itoa_pkg::dp_status_type status,
   output itoa_pkg::dp_cmd_type    cmd
);
   import itoa_pkg::*;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_CONV  = 3'd1;
   localparam logic [2:0] ST_NORM  = 3'd2;
   localparam logic [2:0] ST_SIGN  = 3'd3;
   localparam logic [2:0] ST_PAD   = 3'd4;
   localparam logic [2:0] ST_DIGIT = 3'd5;

   logic [2:0] state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_CONV;
            end
         end
         ST_CONV: begin
            // hex needs no conversion, nibbles already in place
            if (status.hex) begin
               state_in = ST_NORM;
            end else begin
               cmd.conv_step = 1'b1;
               if (status.conv_last) begin
                  state_in = ST_NORM;
               end
            end
         end
         ST_NORM: begin
            if (status.norm_done) begin
               cmd.pad_load = 1'b1;
               state_in     = status.neg ? ST_SIGN : ST_PAD;
            end else begin
               cmd.norm_step = 1'b1;
            end
         end
         ST_SIGN: begin
            if (status.emit_ok) begin
               cmd.emit = 1'b1;
               cmd.sel  = SEL_SIGN;
               state_in = ST_PAD;
            end
         end
         ST_PAD: begin
            if (status.pad_zero) begin
               state_in = ST_DIGIT;
            end else if (status.emit_ok) begin
               cmd.emit    = 1'b1;
               cmd.sel     = SEL_PAD;
               cmd.pad_dec = 1'b1;
            end
         end
         ST_DIGIT: begin
            if (status.emit_ok) begin
               cmd.emit       = 1'b1;
               cmd.sel        = SEL_DIGIT;
               cmd.digit_step = 1'b1;
               if (status.last_digit) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_last_to_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIGIT && cmd.emit && status.last_digit) |=> (state_ff == ST_IDLE))
      else $error("controller did not return to idle after last digit");

endmodule

// ----- tb/tb_integer_to_ascii_formatter_core.sv -----
`timescale 1ns / 1ps
// tb_integer_to_ascii_formatter_core: self-checking bench that predicts each printed number
// and checks every character beat; depends on itoa_pkg and integer_to_ascii_formatter_core

module tb_integer_to_ascii_formatter_core;
   import itoa_pkg::*;

   localparam int MAX_WIDTH = 40;
   localparam int CYCLE_LIMIT = 600000;
   localparam int RANDOM_NUMBERS = 310;
   localparam int HOLD_AFTER_NUMBERS = 110;
   localparam int HOLD_CYCLES = 400;
   localparam int DRAIN_AT_NUMBER = 200;
   localparam int SETTLE_CYCLES = 200;

   // characters the formatter builds its output from
   localparam logic [7:0] ASCII_ZERO    = 8'h30;
   localparam logic [7:0] ASCII_UPPER_A = 8'h41;
   localparam logic [7:0] ASCII_LOWER_A = 8'h61;
   localparam logic [7:0] ASCII_MINUS   = 8'h2d;
   localparam logic [7:0] ASCII_SPACE   = 8'h20;
   localparam logic [7:0] ASCII_STAR    = 8'h2a;

   logic            clock;
   logic            reset;
   logic            req_valid;
   logic            req_ready;
   req_payload_type req_payload;
   logic            rsp_valid;
   logic            rsp_ready;
   rsp_payload_type rsp_payload;

   int numbers_accepted = 0;
   int cycle_count = 0;

   // holds the characters still owed by the block, oldest first
   class char_scoreboard;
      rsp_payload_type pending_chars[$];
      int errors = 0;

      function int pending();
         return pending_chars.size();
      endfunction

      // print one number the way the formatter should and queue its characters
      function void note_number(req_payload_type p);
         logic [63:0]     mag;
         logic [3:0]      d;
         logic [7:0]      ch;
         logic [7:0]      digits[$];
         logic [7:0]      line[$];
         int              width;
         rsp_payload_type beat;
         width = (p.min_width > MAX_WIDTH) ? MAX_WIDTH : int'(p.min_width);
         mag = p.value;
         // sign only for signed decimal; hex ignores the signed flag
         if (p.is_signed && !p.hex_base && p.value[63]) begin
            line.push_back(ASCII_MINUS);
            mag = 64'd0 - p.value;
            if (width > 0) width--;
         end
         if (mag == 64'd0) begin
            digits.push_front(ASCII_ZERO);
         end
         while (mag != 64'd0) begin
            if (p.hex_base) begin
               d = mag[3:0];
               mag = mag >> 4;
            end else begin
               d = 4'(mag % 64'd10);
               mag = mag / 64'd10;
            end
            if (d < 4'd10) ch = ASCII_ZERO + 8'(d);
            else ch = (p.upper_letters ? ASCII_UPPER_A : ASCII_LOWER_A) + 8'(d) - 8'd10;
            digits.push_front(ch);
         end
         // padding sits after the sign, whatever the pad character
         while (digits.size() < width) begin
            line.push_back(p.pad_char);
            width--;
         end
         foreach (digits[i]) line.push_back(digits[i]);
         foreach (line[i]) begin
            beat.out_char = line[i];
            beat.last_char = (i == line.size() - 1);
            pending_chars.push_back(beat);
         end
      endfunction

      function void check_char(rsp_payload_type got);
         rsp_payload_type want;
         if (pending_chars.size() == 0) begin
            $display("%0t: unexpected character beat out_char=%h last_char=%b",
                     $time, got.out_char, got.last_char);
            errors++;
            return;
         end
         want = pending_chars.pop_front();
         if (got.out_char !== want.out_char) begin
            $display("%0t: out_char mismatch expected=%h actual=%h",
                     $time, want.out_char, got.out_char);
            errors++;
         end
         if (got.last_char !== want.last_char) begin
            $display("%0t: last_char mismatch expected=%b actual=%b",
                     $time, want.last_char, got.last_char);
            errors++;
         end
      endfunction
   endclass

   char_scoreboard sb = new();

   integer_to_ascii_formatter_core #(
      .MAX_WIDTH(MAX_WIDTH)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_payload(rsp_payload)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // watchdog: any run still going at the limit is a hang
   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("[integer_to_ascii_formatter_core] ERROR");
      $finish;
   end

   // both channels sampled at the rising edge, drivers move at the falling edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            sb.note_number(req_payload);
            numbers_accepted++;
         end
         if (rsp_valid && rsp_ready) sb.check_char(rsp_payload);
      end
   end

   // receiver: stall odds change per stretch; one long hold-off while numbers keep coming
   initial begin : receiver
      int  stretch_left;
      int  stall_odds;
      int  hold_left;
      bit  hold_done;
      stretch_left = 0;
      stall_odds = 0;
      hold_left = 0;
      hold_done = 1'b0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (!hold_done && numbers_accepted >= HOLD_AFTER_NUMBERS) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
         end
         if (stretch_left == 0) begin
            stretch_left = $urandom_range(8, 120);
            case ($urandom_range(0, 3))
               0: stall_odds = 0;
               1: stall_odds = 25;
               2: stall_odds = 60;
               default: stall_odds = 90;
            endcase
         end
         stretch_left--;
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= stall_odds);
         end
      end
   end

   int burst_left = 0;

   // offer one number in the current burst; a new burst starts after a random gap, which may be zero
   task automatic send_number(input req_payload_type p);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            @(negedge clock);
            req_valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
         burst_left = $urandom_range(1, 10);
      end
      burst_left--;
      @(negedge clock);
      req_valid <= 1'b1;
      req_payload <= p;
      do @(posedge clock); while (!req_ready);
   endtask

   function automatic req_payload_type make_req(logic [63:0] v, logic s, logic h, logic u,
                                                 logic [5:0] w, logic [7:0] pad);
      req_payload_type p;
      p.value = v;
      p.is_signed = s;
      p.hex_base = h;
      p.upper_letters = u;
      p.min_width = w;
      p.pad_char = pad;
      return p;
   endfunction

   // values weighted toward digit-count edges, sign edges and small numbers
   function automatic req_payload_type random_number();
      logic [63:0] v;
      logic [63:0] pow10;
      logic [5:0]  w;
      logic [7:0]  pad;
      int          k;
      case ($urandom_range(0, 6))
         0: v = {$urandom, $urandom};
         1: v = 64'($urandom_range(0, 999));
         2: v = 64'd0 - 64'($urandom_range(1, 999));
         3: begin
            k = $urandom_range(0, 19);
            pow10 = 64'd1;
            repeat (k) pow10 = pow10 * 64'd10;
            v = pow10 + 64'($urandom_range(0, 2)) - 64'd1;
         end
         4: v = (64'd1 << $urandom_range(0, 63)) - 64'($urandom_range(0, 1));
         5: v = {1'b1, 31'($urandom), $urandom};
         default: v = {32'd0, $urandom} >> $urandom_range(0, 31);
      endcase
      case ($urandom_range(0, 4))
         0, 1: w = 6'd0;
         2, 3: w = 6'($urandom_range(1, 24));
         default: w = 6'($urandom_range(0, 63));
      endcase
      case ($urandom_range(0, 3))
         0: pad = ASCII_SPACE;
         1: pad = ASCII_ZERO;
         default: pad = 8'($urandom_range(0, 255));
      endcase
      return make_req(v, 1'($urandom), ($urandom_range(0, 2) == 0), 1'($urandom), w, pad);
   endfunction

   task automatic directed_numbers();
      // zero in both bases, with and without padding
      send_number(make_req(64'd0, 1'b0, 1'b0, 1'b0, 6'd0, ASCII_SPACE));
      send_number(make_req(64'd0, 1'b1, 1'b0, 1'b0, 6'd1, ASCII_SPACE));
      send_number(make_req(64'd0, 1'b0, 1'b1, 1'b0, 6'd5, ASCII_ZERO));
      // largest unsigned value, twenty decimal digits, sixteen hex digits
      send_number(make_req({64{1'b1}}, 1'b0, 1'b0, 1'b0, 6'd0, ASCII_SPACE));
      send_number(make_req({64{1'b1}}, 1'b0, 1'b1, 1'b1, 6'd0, ASCII_SPACE));
      send_number(make_req({64{1'b1}}, 1'b0, 1'b1, 1'b0, 6'd0, ASCII_SPACE));
      send_number(make_req({64{1'b1}}, 1'b0, 1'b0, 1'b0, 6'd20, ASCII_STAR));
      // most negative value, bare and padded after the sign
      send_number(make_req(64'h8000_0000_0000_0000, 1'b1, 1'b0, 1'b0, 6'd0, ASCII_SPACE));
      send_number(make_req(64'h8000_0000_0000_0000, 1'b1, 1'b0, 1'b0, 6'd25, ASCII_ZERO));
      // minus one: width of one is used up by the sign
      send_number(make_req({64{1'b1}}, 1'b1, 1'b0, 1'b0, 6'd1, ASCII_STAR));
      send_number(make_req({64{1'b1}}, 1'b1, 1'b0, 1'b0, 6'd3, ASCII_SPACE));
      // signed flag ignored in hex
      send_number(make_req({64{1'b1}}, 1'b1, 1'b1, 1'b1, 6'd0, ASCII_SPACE));
      send_number(make_req(64'd12345, 1'b1, 1'b0, 1'b0, 6'd10, ASCII_STAR));
      // width saturation around the limit
      send_number(make_req(64'd7, 1'b0, 1'b0, 1'b0, 6'd40, ASCII_SPACE));
      send_number(make_req(64'd7, 1'b0, 1'b0, 1'b0, 6'd41, ASCII_SPACE));
      send_number(make_req(64'd7, 1'b0, 1'b1, 1'b0, 6'd63, 8'hff));
      send_number(make_req(64'd0 - 64'd42, 1'b1, 1'b0, 1'b0, 6'd63, 8'h00));
      // letter case, and its lack of effect in decimal
      send_number(make_req(64'h00ab_cdef, 1'b0, 1'b1, 1'b0, 6'd8, ASCII_ZERO));
      send_number(make_req(64'h00ab_cdef, 1'b0, 1'b1, 1'b1, 6'd8, ASCII_ZERO));
      send_number(make_req(64'd9876543210, 1'b0, 1'b0, 1'b1, 6'd0, ASCII_SPACE));
      send_number(make_req(64'd1000000000000000000, 1'b1, 1'b0, 1'b0, 6'd21, 8'hff));
      send_number(make_req(64'h7fff_ffff_ffff_ffff, 1'b1, 1'b0, 1'b0, 6'd0, ASCII_SPACE));
   endtask

   initial begin : stimulus
      reset = 1'b1;
      req_valid = 1'b0;
      req_payload = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      directed_numbers();
      for (int n = 0; n < RANDOM_NUMBERS; n++) begin
         // once mid-run, let the block drain completely before going on
         if (n == DRAIN_AT_NUMBER) begin
            @(negedge clock);
            req_valid <= 1'b0;
            while (sb.pending() != 0) @(posedge clock);
            burst_left = 0;
         end
         send_number(random_number());
      end
      @(negedge clock);
      req_valid <= 1'b0;

      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.pending() != 0) begin
         $display("%0t: %0d characters never arrived", $time, sb.pending());
         sb.errors++;
      end
      if (sb.errors == 0) begin
         $display("[integer_to_ascii_formatter_core] OK");
      end else begin
         $display("[integer_to_ascii_formatter_core] ERROR");
      end
      $finish;
   end

endmodule
